### sv/esd_pkg.sv
// Shared constants and controller/datapath interface types for the exchange sorter.
`default_nettype none

package esd_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // commands, controller to datapath
    typedef struct packed {
        logic accept_in;
        logic start_sort;
        logic load_ai;
        logic scan;
        logic write_i;
        logic emit_start;
        logic emit_load;
        logic emit_next;
    } cmd_t;

    // loop status, datapath to controller
    typedef struct packed {
        logic i_done;
        logic j_done;
        logic k_final;
    } status_t;

endpackage

`default_nettype wire

### sv/esd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module esd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### sv/esd_ctrl.sv
// Controller state machine: load, exchange-sort sweep and emit sequencing.
`default_nettype none

module esd_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    input  wire logic             s_tlast,
    input  wire logic             m_tready,
    input  wire esd_pkg::status_t status,
    output logic                  s_tready,
    output logic                  m_tvalid,
    output esd_pkg::cmd_t         cmd
);

    typedef enum logic [7:0] {
        ST_LOAD       = 8'b0000_0001,
        ST_SORT_START = 8'b0000_0010,
        ST_LOAD_I     = 8'b0000_0100,
        ST_SCAN       = 8'b0000_1000,
        ST_WRITE_I    = 8'b0001_0000,
        ST_EMIT_START = 8'b0010_0000,
        ST_EMIT_LOAD  = 8'b0100_0000,
        ST_EMIT_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept_in = 1'b1;
                    if (s_tlast)
                    begin
                        state_next = ST_SORT_START;
                    end
                end
            end
            ST_SORT_START:
            begin
                cmd.start_sort = 1'b1;
                state_next     = ST_LOAD_I;
            end
            ST_LOAD_I:
            begin
                cmd.load_ai = 1'b1;
                state_next  = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.j_done)
                begin
                    state_next = ST_WRITE_I;
                end
            end
            ST_WRITE_I:
            begin
                cmd.write_i = 1'b1;
                state_next  = status.i_done ? ST_EMIT_START : ST_LOAD_I;
            end
            ST_EMIT_START:
            begin
                cmd.emit_start = 1'b1;
                state_next     = ST_EMIT_LOAD;
            end
            ST_EMIT_LOAD:
            begin
                cmd.emit_load = 1'b1;
                state_next    = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    if (status.k_final)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        cmd.emit_next = 1'b1;
                        state_next    = ST_EMIT_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### sv/esd_dp.sv
// Datapath: element store, loop indices, compare-swap and output register.
`default_nettype none

module esd_dp (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire esd_pkg::cmd_t                cmd,
    input  wire logic [esd_pkg::DATA_W-1:0]   in_value,
    input  wire logic                         in_last,
    output esd_pkg::status_t                  status,
    output logic      [esd_pkg::DATA_W-1:0]   out_value,
    output logic                              out_last
);

    localparam int AW = esd_pkg::ADDR_W;
    localparam int CW = esd_pkg::CNT_W;
    localparam int DW = esd_pkg::DATA_W;

    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;
    logic [AW-1:0] last_idx_reg;
    logic [AW-1:0] last_idx_next;
    logic [AW-1:0] i_reg;
    logic [AW-1:0] i_next;
    logic [AW-1:0] j_reg;
    logic [AW-1:0] j_next;
    logic [AW-1:0] k_reg;
    logic [AW-1:0] k_next;
    logic signed [DW-1:0] ai_reg;
    logic signed [DW-1:0] ai_next;
    logic [DW-1:0] out_value_reg;
    logic [DW-1:0] out_value_next;
    logic          out_last_reg;
    logic          out_last_next;

    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic [AW-1:0] raddr;
    logic [DW-1:0] rdata;
    logic          room;
    logic          swap;

    esd_ram #(
        .WIDTH (DW),
        .DEPTH (esd_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign room = (fill_reg < CW'(esd_pkg::DEPTH));
    // entry i lives in ai_reg during its sweep, so j == i is never compared
    assign swap = (j_reg != i_reg) && (ai_reg > $signed(rdata));

    assign status.i_done  = (i_reg == last_idx_reg);
    assign status.j_done  = (j_reg == last_idx_reg);
    assign status.k_final = (k_reg == last_idx_reg);

    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

    always_comb
    begin
        fill_next      = fill_reg;
        last_idx_next  = last_idx_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        ai_next        = ai_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        we             = 1'b0;
        waddr          = '0;
        wdata          = '0;
        raddr          = '0;

        if (cmd.accept_in)
        begin
            if (room)
            begin
                we        = 1'b1;
                waddr     = fill_reg[AW-1:0];
                wdata     = in_value;
                fill_next = fill_reg + CW'(1);
            end
            if (in_last)
            begin
                last_idx_next = room ? fill_reg[AW-1:0] : AW'(esd_pkg::DEPTH - 1);
                fill_next     = '0;
            end
        end

        if (cmd.start_sort)
        begin
            i_next = '0;
            raddr  = '0;
        end

        if (cmd.load_ai)
        begin
            ai_next = rdata;
            j_next  = '0;
            raddr   = '0;
        end

        if (cmd.scan)
        begin
            if (swap)
            begin
                we      = 1'b1;
                waddr   = j_reg;
                wdata   = ai_reg;
                ai_next = rdata;
            end
            j_next = j_reg + AW'(1);
            raddr  = j_reg + AW'(1);
        end

        if (cmd.write_i)
        begin
            we     = 1'b1;
            waddr  = i_reg;
            wdata  = ai_reg;
            i_next = i_reg + AW'(1);
            raddr  = i_reg + AW'(1);
        end

        if (cmd.emit_start)
        begin
            k_next = '0;
            raddr  = '0;
        end

        if (cmd.emit_load)
        begin
            out_value_next = rdata;
            out_last_next  = status.k_final;
        end

        if (cmd.emit_next)
        begin
            k_next = k_reg + AW'(1);
            raddr  = k_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_idx_reg  <= last_idx_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        ai_reg        <= ai_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(esd_pkg::DEPTH))
        else $error("fill count beyond store depth");

    a_fill_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept_in && in_last) |=> (fill_reg == '0))
        else $error("fill count not cleared after last request");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> ((j_reg <= last_idx_reg) && (i_reg <= last_idx_reg)))
        else $error("sort index outside loaded set");

endmodule

`default_nettype wire

### sv/exchange_sort_descending_top.sv
// Top level of the descending exchange sorter: controller plus datapath.
// Load: one request per cycle while collecting; the last request starts the sort.
// Sort: one RAM read per inner step over the n buffered entries.
// Emit: EMIT_START and EMIT_LOAD come before the first result; each further result passes EMIT_LOAD again.
// rst_n is asynchronous, active low: clears controller and fill count, store undefined.
`default_nettype none

module exchange_sort_descending_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value (signed)
    input  wire logic        s_tlast,   // last element of the set
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [31:0] sorted_value (signed)
    output logic             m_tlast    // final_res
);

    esd_pkg::cmd_t    cmd;
    esd_pkg::status_t status;

    // sequencer: requests are taken only while collecting; the rest is sort and emit
    esd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .status   (status),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    // store, indices and comparator; surplus values past the depth are dropped
    esd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_value  (s_tdata),
        .in_last   (s_tlast),
        .status    (status),
        .out_value (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

`default_nettype wire

### tb/sorted_run_checker.sv
`timescale 1ns / 100ps
// Checker for the exchange sorter: predicts each sorted run from accepted requests and compares.
module sorted_run_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tlast,
    output int          mismatches,
    output int          results_pending
);

    typedef struct {
        logic signed [esd_pkg::DATA_W-1:0] sorted_value;
        logic                              final_res;
    } sorted_item_t;

    logic signed [esd_pkg::DATA_W-1:0] loaded_values [esd_pkg::DEPTH];
    int                                load_count;
    sorted_item_t                      expected_sorted [$];
    int                                results_seen;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        begin
            $display("%0t: result %0d: %s: got %0d, expected %0d",
                     $realtime, results_seen, what, got, want);
            mismatches++;
        end
    endtask

    // store the request if there is room; on last, sort descending and queue the run
    task automatic predict_request(input logic signed [31:0] value, input logic last_flag);
        int                 n;
        logic signed [31:0] tmp;
        sorted_item_t       item;
        begin
            if (load_count < esd_pkg::DEPTH)
            begin
                loaded_values[load_count] = value;
                load_count++;
            end
            if (last_flag)
            begin
                n = load_count;
                for (int i = 0; i < n; i++)
                begin
                    for (int j = 0; j < n; j++)
                    begin
                        if (loaded_values[i] > loaded_values[j])
                        begin
                            tmp              = loaded_values[i];
                            loaded_values[i] = loaded_values[j];
                            loaded_values[j] = tmp;
                        end
                    end
                end
                for (int k = 0; k < n; k++)
                begin
                    item.sorted_value = loaded_values[k];
                    item.final_res    = (k == n - 1);
                    expected_sorted.push_back(item);
                end
                load_count = 0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_sorted.delete();
            load_count   = 0;
            results_seen = 0;
            mismatches   = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_sorted.size() == 0)
                    report_mismatch("unexpected result", $signed(m_tdata), 0);
                else
                begin
                    if (m_tdata !== expected_sorted[0].sorted_value)
                        report_mismatch("sorted_value", $signed(m_tdata),
                                        expected_sorted[0].sorted_value);
                    if (m_tlast !== expected_sorted[0].final_res)
                        report_mismatch("final_res", m_tlast, expected_sorted[0].final_res);
                    void'(expected_sorted.pop_front());
                end
                results_seen++;
            end
            if (s_tvalid && s_tready)
                predict_request(s_tdata, s_tlast);
        end
        results_pending = expected_sorted.size();
    end

endmodule

### tb/tb_exchange_sort_descending_top.sv
`timescale 1ns / 100ps
// Testbench top for the exchange sorter: request stimulus, output stalls, watchdog and verdict.
module tb_exchange_sort_descending_top;

    localparam int STALL_LIMIT    = 4000;  // cycles with no request or result moving
    localparam int DRAIN_CYCLES   = 50;    // quiet time after the last result
    localparam int PHASE_REQUESTS = 34;    // requests per idling phase, directed ones included

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    int mismatches;
    int results_pending;
    int src_idle_pct   = 0;
    int sink_idle_pct  = 0;
    int quiet_cycles   = 0;
    int phase_requests = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    exchange_sort_descending_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    sorted_run_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .mismatches      (mismatches),
        .results_pending (results_pending)
    );

    // receiver: stalls at random, one decision per cycle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // watchdog: the sort of a full set is the longest legal quiet spell
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one request; optional random gap first, handshake sampled at the falling edge
    task automatic send_request(input logic [31:0] value, input logic last_flag);
        bit taken;
        begin
            while ($urandom_range(0, 99) < src_idle_pct)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= value;
            s_tlast  <= last_flag;
            taken = 1'b0;
            while (!taken)
            begin
                @(negedge clk);
                taken = s_tready;
                @(posedge clk);
            end
            phase_requests++;
        end
    endtask

    // hold off the sender until every queued result has come out
    task automatic drain_results();
        begin
            s_tvalid <= 1'b0;
            s_tlast  <= 1'b0;
            @(negedge clk);
            while (results_pending != 0)
                @(negedge clk);
            @(posedge clk);
        end
    endtask

    // extremes, clusters of near-equal values, and fully random words
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        begin
            case ($urandom_range(0, 9))
                0:       v = 32'h8000_0000;
                1:       v = 32'h7FFF_FFFF;
                2, 3:    v = $urandom_range(0, 7) - 4;
                default: v = $urandom;
            endcase
            return v;
        end
    endfunction

    // mostly short sets; now and then exactly full or overflowing the store
    function automatic int pick_set_size();
        int r;
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                return esd_pkg::DEPTH;
            else if (r == 1)
                return $urandom_range(esd_pkg::DEPTH + 1, esd_pkg::DEPTH + 3);
            else
                return $urandom_range(1, 8);
        end
    endfunction

    task automatic send_set(input int count);
        begin
            for (int i = 0; i < count; i++)
                send_request(pick_value(), i == count - 1);
        end
    endtask

    initial
    begin
        int target;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++)
        begin
            // sender/receiver idling: 37/57, then 57/37, then none
            case (phase)
                0:       begin src_idle_pct = 37; sink_idle_pct = 57; end
                1:       begin src_idle_pct = 57; sink_idle_pct = 37; end
                default: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
            endcase
            phase_requests = 0;
            target         = PHASE_REQUESTS;

            if (phase == 0)
            begin
                // single-element set
                send_request(32'h7FFF_FFFF, 1'b1);
                // most negative, most positive and minus one: signed ordering
                send_request(32'h8000_0000, 1'b0);
                send_request(32'h7FFF_FFFF, 1'b0);
                send_request(32'hFFFF_FFFF, 1'b1);
                // equal values never swap
                send_request(32'd3, 1'b0);
                send_request(-32'sd3, 1'b0);
                send_request(32'd3, 1'b1);
                // store full: two extra requests dropped, last marker on the dropped one
                for (int i = 0; i < esd_pkg::DEPTH; i++)
                    send_request(i * 32'h1357_9BDF, 1'b0);
                send_request(32'h7FFF_FFFE, 1'b0);
                send_request(32'h7FFF_FFFF, 1'b1);
            end

            while (phase_requests < target)
                send_set(pick_set_size());
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && results_pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
